/* rtl/spm_pkg.sv */
`timescale 1ns / 1ps

package spm_pkg;

    localparam int MAX_TOKENS_DEF = 16;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    // Broadcast to every cell for the word being accepted.
    typedef struct packed {
        logic       fire;
        t_func      func;
        logic [7:0] symbol;
        logic       starred;
    } t_ctrl;

    // Handed from one cell to the next along the chain.
    typedef struct packed {
        logic valid_now;
        logic valid_nxt;
        logic carry;
    } t_link;

    // Per-cell activity, used for the reduction at the top level.
    typedef struct packed {
        logic act_now;
        logic end_now;
        logic act_nxt;
        logic end_nxt;
    } t_tap;

endpackage

/* rtl/spm_cell.sv */
`timescale 1ns / 1ps

module spm_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spm_pkg::t_ctrl i_ctrl,
    input  spm_pkg::t_link i_link,
    output spm_pkg::t_link o_link,
    output spm_pkg::t_tap  o_tap
);
    import spm_pkg::*;

    logic       r_valid;
    logic       r_act;
    logic       r_star;
    logic [7:0] r_byte;

    logic n_valid;
    logic n_act;
    logic n_star;
    logic w_restart;
    logic w_target;
    logic w_hit;

    always_comb begin
        w_restart = (i_ctrl.func != FUNC_TEXT);
        // The first empty cell after the filled ones takes an appended token.
        w_target  = (i_ctrl.func == FUNC_APPEND) && i_link.valid_now && !r_valid;
        w_hit     = r_valid && r_act && (r_byte == i_ctrl.symbol);
        n_valid   = (i_ctrl.func == FUNC_CLEAR) ? 1'b0 : (r_valid | w_target);
        n_star    = w_target ? i_ctrl.starred : r_star;
        // A starred token that matches stays active; the carry from the left
        // brings both advances and star closure from earlier positions.
        n_act     = (!w_restart && w_hit && r_star) | i_link.carry;

        o_link.valid_now = r_valid;
        o_link.valid_nxt = n_valid;
        o_link.carry     = n_valid & ((n_act & n_star) | (!w_restart & w_hit & !r_star));

        o_tap.act_now = r_act;
        o_tap.end_now = i_link.valid_now & !r_valid;
        o_tap.act_nxt = n_act;
        o_tap.end_nxt = i_link.valid_nxt & !n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_act   <= IS_HEAD;
        end else if (i_ctrl.fire) begin
            r_valid <= n_valid;
            r_act   <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && w_target) begin
            r_byte <= i_ctrl.symbol;
            r_star <= i_ctrl.starred;
        end
    end

endmodule

/* rtl/star_pattern_matcher_top.sv */
`timescale 1ns / 1ps

// Whole-string matcher for a pattern of literal bytes, each optionally starred
// (zero or more repeats). Send func 0 to clear the pattern, func 1 to append a
// token (symbol, starred), func 2 for each text byte and func 3 to report and
// restart the text. Every accepted word yields exactly one result word:
// matched, alive and overflow (an append past MAX_TOKENS tokens is dropped).
// The pattern lives in a chain of MAX_TOKENS cells, one per token, and a text
// byte updates all of them in the same cycle, so one word is accepted every
// clock while the output side takes results. Results are registered, and a
// two-entry output stage (output register and skid entry) lets the input take
// one more word after the output stalls.
module star_pattern_matcher_top #(
    parameter int MAX_TOKENS = spm_pkg::MAX_TOKENS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_symbol,
    input  logic       i_starred,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_alive,
    output logic       o_overflow
);
    import spm_pkg::*;

    t_ctrl w_ctrl;
    t_link w_link [0:MAX_TOKENS];
    t_tap  w_tap  [0:MAX_TOKENS-1];

    logic                  r_act_end;
    logic                  w_fire;
    logic                  w_matched;
    logic                  w_alive;
    logic                  w_overflow;
    logic                  w_m_now;
    logic                  w_a_now;
    logic                  w_m_nxt;
    logic                  w_a_nxt;
    logic [MAX_TOKENS-1:0] w_valid_vec;
    logic [MAX_TOKENS-1:0] w_act_hi;

    logic r_out_valid;
    logic r_matched;
    logic r_alive;
    logic r_overflow;
    logic r_sk_valid;
    logic r_sk_matched;
    logic r_sk_alive;
    logic r_sk_overflow;

    assign o_in_ready = !r_sk_valid;
    assign w_fire     = i_in_valid && o_in_ready;

    always_comb begin
        w_ctrl.fire    = w_fire;
        w_ctrl.func    = t_func'(i_func);
        w_ctrl.symbol  = i_symbol;
        w_ctrl.starred = i_starred;
    end

    assign w_link[0].valid_now = 1'b1;
    assign w_link[0].valid_nxt = 1'b1;
    assign w_link[0].carry     = (w_ctrl.func != FUNC_TEXT);

    for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
        spm_cell #(
            .IS_HEAD (g == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_tap   (w_tap[g])
        );
        assign w_valid_vec[g] = w_link[g+1].valid_now;
    end

    // The position past the last cell only exists as the end of a full pattern.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_end <= 1'b0;
        end else if (w_fire) begin
            r_act_end <= w_link[MAX_TOKENS].carry;
        end
    end

    always_comb begin
        w_m_now = w_link[MAX_TOKENS].valid_now & r_act_end;
        w_a_now = r_act_end;
        w_m_nxt = w_link[MAX_TOKENS].valid_nxt & w_link[MAX_TOKENS].carry;
        w_a_nxt = w_link[MAX_TOKENS].carry;
        for (int p = 0; p < MAX_TOKENS; p++) begin
            w_m_now = w_m_now | (w_tap[p].act_now & w_tap[p].end_now);
            w_a_now = w_a_now | w_tap[p].act_now;
            w_m_nxt = w_m_nxt | (w_tap[p].act_nxt & w_tap[p].end_nxt);
            w_a_nxt = w_a_nxt | w_tap[p].act_nxt;
        end
        // End of text reports the text so far, before the restart.
        w_matched  = (w_ctrl.func == FUNC_END) ? w_m_now : w_m_nxt;
        w_alive    = (w_ctrl.func == FUNC_END) ? w_a_now : w_a_nxt;
        w_overflow = (w_ctrl.func == FUNC_APPEND) && w_link[MAX_TOKENS].valid_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (w_fire) begin
                r_sk_valid <= 1'b1;
            end
        end else if (r_sk_valid) begin
            r_out_valid <= 1'b1;
            r_sk_valid  <= 1'b0;
        end else begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (w_fire) begin
                r_sk_matched  <= w_matched;
                r_sk_alive    <= w_alive;
                r_sk_overflow <= w_overflow;
            end
        end else if (r_sk_valid) begin
            r_matched  <= r_sk_matched;
            r_alive    <= r_sk_alive;
            r_overflow <= r_sk_overflow;
        end else begin
            r_matched  <= w_matched;
            r_alive    <= w_alive;
            r_overflow <= w_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;
    assign o_alive     = r_alive;
    assign o_overflow  = r_overflow;

    always_comb begin
        for (int p = 0; p < MAX_TOKENS - 1; p++) begin
            w_act_hi[p] = w_tap[p+1].act_now;
        end
        w_act_hi[MAX_TOKENS-1] = r_act_end;
    end

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry valid while output register is empty");

    // Filled token cells form an unbroken run from the head of the chain.
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
        else $error("token cells are not filled contiguously");

    // No position beyond the end of the loaded pattern is ever active.
    a_act_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_act_hi & ~w_valid_vec) == '0)
        else $error("active position beyond the loaded pattern");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_ctrl.func == FUNC_CLEAR) |=> (w_valid_vec == '0))
        else $error("token cells still filled after a clear");

endmodule
